[hdl/tea_block_cipher_core_macros.svh]
// assertion macros shared by the tea cipher checker
`ifndef TEA_BLOCK_CIPHER_CORE_MACROS_SVH
`define TEA_BLOCK_CIPHER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TEA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tea core: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define TEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tea core: next-cycle check failed");

`endif

[hdl/tea_pkg.sv]
// shared types, constants and round function of the tea cipher core
package tea_pkg;

    localparam int ROUNDS_DEF = 32;
    localparam int ROUNDS_MIN = 8;
    localparam int ROUNDS_MAX = 64;

    localparam int WORD_W  = 32;
    localparam int KEY_NUM = 4;
    localparam int ADDR_W  = 3;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [ADDR_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [ADDR_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [ADDR_W-1:0] REG_KEY3 = 3'd3;

    // operation selector codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [KEY_NUM-1:0][WORD_W-1:0] tea_key_t;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] block_first;
        logic [WORD_W-1:0] block_second;
    } tea_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_first;
        logic [WORD_W-1:0] out_second;
    } tea_out_t;

    typedef struct packed {
        logic              valid;
        logic              op;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } tea_pipe_t;

    function automatic logic [WORD_W-1:0] mix(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

endpackage

[hdl/tea_cell.sv]
// one tea cycle as two registered half-rounds, encrypt or decrypt per item
module tea_cell #(
    parameter logic [tea_pkg::WORD_W-1:0] SUM_ENC = tea_pkg::DELTA,
    parameter logic [tea_pkg::WORD_W-1:0] SUM_DEC = tea_pkg::DELTA
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  tea_pkg::tea_key_t  key,
    input  tea_pkg::tea_pipe_t pipe_in,
    output tea_pkg::tea_pipe_t pipe_out
);

    tea_pkg::tea_pipe_t half_reg, half_next;
    tea_pkg::tea_pipe_t full_reg, full_next;

    logic                       dec_a, dec_b;
    logic [tea_pkg::WORD_W-1:0] sum_a, sum_b;
    logic [tea_pkg::WORD_W-1:0] mix_a, mix_b;

    // first half: encrypt updates v0 from v1, decrypt undoes v1 from v0
    always_comb begin
        dec_a = (pipe_in.op == tea_pkg::OP_DECRYPT);
        sum_a = dec_a ? SUM_DEC : SUM_ENC;
        mix_a = dec_a ? tea_pkg::mix(pipe_in.v0, sum_a, key[2], key[3])
                      : tea_pkg::mix(pipe_in.v1, sum_a, key[0], key[1]);
        half_next = pipe_in;
        if (dec_a) begin
            half_next.v1 = pipe_in.v1 - mix_a;
        end else begin
            half_next.v0 = pipe_in.v0 + mix_a;
        end
    end

    // second half: the other word
    always_comb begin
        dec_b = (half_reg.op == tea_pkg::OP_DECRYPT);
        sum_b = dec_b ? SUM_DEC : SUM_ENC;
        mix_b = dec_b ? tea_pkg::mix(half_reg.v1, sum_b, key[0], key[1])
                      : tea_pkg::mix(half_reg.v0, sum_b, key[2], key[3]);
        full_next = half_reg;
        if (dec_b) begin
            full_next.v0 = half_reg.v0 - mix_b;
        end else begin
            full_next.v1 = half_reg.v1 + mix_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg.valid <= 1'b0;
            full_reg.valid <= 1'b0;
        end else if (en) begin
            half_reg <= half_next;
            full_reg <= full_next;
        end
    end

    assign pipe_out = full_reg;

endmodule

[hdl/tea_out_buf.sv]
// output register with one skid entry
module tea_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  tea_pkg::tea_out_t in_data,
    output logic              in_ready,
    output logic              m_valid,
    output tea_pkg::tea_out_t m_data,
    input  logic              m_ready
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    tea_pkg::tea_out_t out_data_reg, out_data_next;
    tea_pkg::tea_out_t skid_data_reg, skid_data_next;
    logic              pop;

    always_comb begin
        pop             = out_valid_reg && m_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

endmodule

[hdl/tea_block_cipher_core.sv]
// top level of the pipelined tea block cipher core
// usage:
//   s_valid/s_ready/s_data carry one request: op (0 encrypt, 1 decrypt)
//   and the two 32-bit block halves. m_valid/m_ready/m_data return one
//   result block per request, in request order.
//   the 128-bit key is written as four words through cfg_wr_en, cfg_addr
//   (0..3, higher indexes are ignored) and cfg_wdata; write it only while
//   no request is in flight.
// structure: a row of ROUNDS cells, each one tea cycle split into two
//   registered half-rounds, plus the output register that drives m_valid.
// throughput: one request per cycle while s_ready is high, set by the
//   cell row, which moves every cycle unless the skid entry is full;
//   encrypt and decrypt may be mixed freely.
// stall: while the receiver holds m_ready low the output register keeps
//   the result and the row keeps moving until one more result lands in
//   the skid entry; then s_ready drops and the whole row freezes.
// reset: aresetn low clears all valid bits and the key words to zero.
module tea_block_cipher_core #(
    parameter int ROUNDS = tea_pkg::ROUNDS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tea_pkg::tea_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tea_pkg::tea_out_t           m_data,
    input  logic                        cfg_wr_en,
    input  logic [tea_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [tea_pkg::WORD_W-1:0]  cfg_wdata
);

    // key words
    tea_pkg::tea_key_t key_reg, key_next;

    always_comb begin
        key_next = key_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                tea_pkg::REG_KEY0: key_next[0] = cfg_wdata;
                tea_pkg::REG_KEY1: key_next[1] = cfg_wdata;
                tea_pkg::REG_KEY2: key_next[2] = cfg_wdata;
                tea_pkg::REG_KEY3: key_next[3] = cfg_wdata;
                default:           key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    // the whole row advances together, gated by the skid entry
    logic               row_en;
    logic               buf_ready;
    tea_pkg::tea_pipe_t chain [ROUNDS+1];
    tea_pkg::tea_out_t  last_data;

    assign row_en  = buf_ready;
    assign s_ready = buf_ready;

    // cell 0 sees the request; valid marks an accepted request
    always_comb begin
        chain[0].valid = s_valid;
        chain[0].op    = s_data.op;
        chain[0].v0    = s_data.block_first;
        chain[0].v1    = s_data.block_second;
    end

    // encrypt cycle r uses sum (r+1)*delta, decrypt runs the sums backwards
    for (genvar r = 0; r < ROUNDS; r++) begin : g_cell
        localparam logic [tea_pkg::WORD_W-1:0] SUM_E =
            tea_pkg::WORD_W'(tea_pkg::WORD_W'(r + 1) * tea_pkg::DELTA);
        localparam logic [tea_pkg::WORD_W-1:0] SUM_D =
            tea_pkg::WORD_W'(tea_pkg::WORD_W'(ROUNDS - r) * tea_pkg::DELTA);

        tea_cell #(
            .SUM_ENC(SUM_E),
            .SUM_DEC(SUM_D)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (row_en),
            .key     (key_reg),
            .pipe_in (chain[r]),
            .pipe_out(chain[r+1])
        );
    end

    assign last_data.out_first  = chain[ROUNDS].v0;
    assign last_data.out_second = chain[ROUNDS].v1;

    // the last cell only hands over when the row moves
    tea_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(chain[ROUNDS].valid && row_en),
        .in_data (last_data),
        .in_ready(buf_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .m_ready (m_ready)
    );

endmodule

[hdl/tea_chk.sv]
// port-level checks of the tea cipher core and their binding
`include "tea_block_cipher_core_macros.svh"

module tea_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input tea_pkg::tea_out_t m_data
);

    // a stalled result holds
    `TEA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // backpressure on the input only with a result waiting at the output
    `TEA_ASSERT_SAME(a_stall_has_result, aclk, aresetn, !s_ready, m_valid)

    // backpressure only follows a cycle in which the receiver refused a result
    `TEA_ASSERT_SAME(a_stall_cause, aclk, aresetn, !s_ready, $past(m_valid && !m_ready))

    // a refused result with the input still open leaves the output occupied
    `TEA_ASSERT_NEXT(a_keep_full, aclk, aresetn, m_valid && !m_ready && s_valid && s_ready, m_valid)

endmodule

bind tea_block_cipher_core tea_chk u_tea_chk (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
